FILE: rtl/swlc_pkg.sv
// shared constants, types and helpers of the sector write-back lru cache
`default_nettype none
package swlc_pkg;

  localparam int NAMESPACES = 4;
  localparam int ENTRIES    = 16;
  localparam int SECTORS    = 8;
  localparam int ADDR_W     = 32;

  localparam int NS_W    = 3;
  localparam int NSX_W   = 2;
  localparam int WAY_W   = 4;
  localparam int SLOTS   = NAMESPACES * ENTRIES;
  localparam int SLOT_W  = NSX_W + WAY_W;
  localparam int AGE_W   = 4;
  localparam int CNT_W   = WAY_W + 1;
  localparam int OCC_W   = 5;
  localparam int CAP_W   = 5;
  localparam int POP_W   = 4;
  localparam int CFG_W   = 2;
  localparam int CFG_D_W = 5;

  typedef enum logic [CFG_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_NSU  = 2'd1,
    CFG_CAP  = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_AGE,
    ST_COMMIT,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic load;
    logic search_start;
    logic age_start;
    logic commit;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic is_write;
    logic hit;
    logic sweep_done;
    logic out_busy;
  } sts_t;

  function automatic logic [POP_W-1:0] popcount(input logic [SECTORS-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < SECTORS; i++) begin
      c = c + POP_W'(v[i]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sector_write_back_lru_cache_core.sv
// top level of the sector write-back lru page cache
// One page transaction at a time. A bad namespace or no-cache item goes from
// the decide state straight to the respond state. A cached item sweeps the 16
// ways of its namespace through the tag, mask and age memories, one way per
// cycle. A read miss then answers. A write hit then merges its sectors in the
// commit state. A read hit or write miss runs a second sweep to rerank the lru
// ages before the commit state stores a write miss's page or clears the age of
// a read hit's way. The single read port of the stores sets the sweep length.
// A result waits in an output register while the next item is taken; an item
// whose result is ready stalls until that register is free. No clearing pass
// is run.
`default_nettype none
module sector_write_back_lru_cache_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [swlc_pkg::CFG_W-1:0]   cfg_index,
  input  wire logic [swlc_pkg::CFG_D_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic [swlc_pkg::NS_W-1:0]    in_namespace_id,
  input  wire logic [swlc_pkg::ADDR_W-1:0]  in_page_address,
  input  wire logic [swlc_pkg::SECTORS-1:0] in_sector_mask,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_fully_served,
  output logic [swlc_pkg::SECTORS-1:0]      out_forward_mask,
  output logic [swlc_pkg::POP_W-1:0]        out_forward_sectors,
  output logic                              out_writeback_valid,
  output logic [swlc_pkg::NS_W-1:0]         out_writeback_namespace,
  output logic [swlc_pkg::ADDR_W-1:0]       out_writeback_address,
  output logic [swlc_pkg::SECTORS-1:0]      out_writeback_mask,
  output logic [swlc_pkg::POP_W-1:0]        out_writeback_sectors,
  output logic                              out_bad_namespace
);

  swlc_pkg::cmd_t cmd;
  swlc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  swlc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .sts, .cmd
  );

  swlc_dpath u_dpath (
    .clk, .rst_n,
    .cfg_valid, .cfg_index, .cfg_data,
    .in_kind, .in_namespace_id, .in_page_address, .in_sector_mask,
    .cmd, .sts,
    .out_valid, .out_ready,
    .out_fully_served, .out_forward_mask, .out_forward_sectors,
    .out_writeback_valid, .out_writeback_namespace, .out_writeback_address,
    .out_writeback_mask, .out_writeback_sectors, .out_bad_namespace
  );

endmodule
`default_nettype wire

FILE: rtl/swlc_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module swlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/swlc_ctrl.sv
// transaction sequencer of the cache
`default_nettype none
module swlc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire swlc_pkg::sts_t sts,
  output swlc_pkg::cmd_t      cmd
);

  swlc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swlc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swlc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = swlc_pkg::ST_DECIDE;
      end
      swlc_pkg::ST_DECIDE: begin
        state_nxt = sts.bypass ? swlc_pkg::ST_RESPOND : swlc_pkg::ST_SEARCH;
      end
      swlc_pkg::ST_SEARCH: begin
        if (sts.sweep_done) begin
          priority if (sts.is_write && sts.hit) state_nxt = swlc_pkg::ST_COMMIT;
          else if (sts.is_write || sts.hit)     state_nxt = swlc_pkg::ST_AGE;
          else                                  state_nxt = swlc_pkg::ST_RESPOND;
        end
      end
      swlc_pkg::ST_AGE: begin
        if (sts.sweep_done) state_nxt = swlc_pkg::ST_COMMIT;
      end
      swlc_pkg::ST_COMMIT: begin
        state_nxt = swlc_pkg::ST_RESPOND;
      end
      swlc_pkg::ST_RESPOND: begin
        if (!sts.out_busy) state_nxt = swlc_pkg::ST_IDLE;
      end
      default: state_nxt = swlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      swlc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      swlc_pkg::ST_DECIDE: begin
        cmd.search_start = !sts.bypass;
      end
      swlc_pkg::ST_SEARCH: begin
        cmd.age_start = sts.sweep_done && (sts.is_write != sts.hit || !sts.is_write && sts.hit);
      end
      swlc_pkg::ST_AGE: begin
      end
      swlc_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      swlc_pkg::ST_RESPOND: begin
        cmd.respond = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == swlc_pkg::ST_DECIDE)
    else $error("accepted beat did not move to decide");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == swlc_pkg::ST_RESPOND)
    else $error("commit not followed by respond");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.search_start, cmd.age_start, cmd.commit, cmd.respond}))
    else $error("more than one command at once");

endmodule
`default_nettype wire

FILE: rtl/swlc_dpath.sv
// cache datapath: config, tag and mask stores, lru ages, sweep unit, result register
`default_nettype none
module swlc_dpath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [swlc_pkg::CFG_W-1:0]       cfg_index,
  input  wire logic [swlc_pkg::CFG_D_W-1:0]     cfg_data,
  input  wire logic                             in_kind,
  input  wire logic [swlc_pkg::NS_W-1:0]        in_namespace_id,
  input  wire logic [swlc_pkg::ADDR_W-1:0]      in_page_address,
  input  wire logic [swlc_pkg::SECTORS-1:0]     in_sector_mask,
  input  wire swlc_pkg::cmd_t                   cmd,
  output swlc_pkg::sts_t                        sts,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_fully_served,
  output logic [swlc_pkg::SECTORS-1:0]          out_forward_mask,
  output logic [swlc_pkg::POP_W-1:0]            out_forward_sectors,
  output logic                                  out_writeback_valid,
  output logic [swlc_pkg::NS_W-1:0]             out_writeback_namespace,
  output logic [swlc_pkg::ADDR_W-1:0]           out_writeback_address,
  output logic [swlc_pkg::SECTORS-1:0]          out_writeback_mask,
  output logic [swlc_pkg::POP_W-1:0]            out_writeback_sectors,
  output logic                                  out_bad_namespace
);

  localparam int SW = swlc_pkg::SLOT_W;
  localparam int WW = swlc_pkg::WAY_W;
  localparam int AW = swlc_pkg::AGE_W;
  localparam int MW = swlc_pkg::SECTORS;
  localparam int DW = swlc_pkg::ADDR_W;

  // configuration
  logic                       mode_r;
  logic [swlc_pkg::NS_W-1:0]  nsu_r;
  logic [swlc_pkg::CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      nsu_r  <= swlc_pkg::NS_W'(1);
      cap_r  <= swlc_pkg::CAP_W'(swlc_pkg::ENTRIES);
    end else if (cfg_valid) begin
      unique case (swlc_pkg::cfg_idx_t'(cfg_index))
        swlc_pkg::CFG_MODE: mode_r <= cfg_data[0];
        swlc_pkg::CFG_NSU:  nsu_r  <= cfg_data[swlc_pkg::NS_W-1:0];
        swlc_pkg::CFG_CAP:  cap_r  <= cfg_data[swlc_pkg::CAP_W-1:0];
        swlc_pkg::CFG_NONE: ;
        default: ;
      endcase
    end
  end

  logic [swlc_pkg::NS_W-1:0]  ns_lim;
  logic [swlc_pkg::CAP_W-1:0] cap_eff;
  logic                       in_bad;

  always_comb begin
    ns_lim = (nsu_r > swlc_pkg::NS_W'(swlc_pkg::NAMESPACES)) ?
             swlc_pkg::NS_W'(swlc_pkg::NAMESPACES) : nsu_r;
    in_bad = (in_namespace_id == '0) || (in_namespace_id > ns_lim);
    priority if (cap_r == '0)                                 cap_eff = swlc_pkg::CAP_W'(1);
    else if (cap_r > swlc_pkg::CAP_W'(swlc_pkg::ENTRIES))     cap_eff = swlc_pkg::CAP_W'(swlc_pkg::ENTRIES);
    else                                                      cap_eff = cap_r;
  end

  // captured transaction
  logic                       kind_r, bad_r, byp_r;
  logic [swlc_pkg::NSX_W-1:0] nsx_r;
  logic [swlc_pkg::NS_W-1:0]  nsid_r;
  logic [DW-1:0]              addr_r;
  logic [MW-1:0]              mask_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      bad_r  <= in_bad;
      byp_r  <= !in_bad && !mode_r;
      nsid_r <= in_namespace_id;
      nsx_r  <= swlc_pkg::NSX_W'(in_namespace_id - swlc_pkg::NS_W'(1));
      addr_r <= in_page_address;
      mask_r <= in_sector_mask;
    end
  end

  // sweep over the ways of one namespace, one read issued per cycle
  logic            sweep_r, age_mode_r, rdv_r;
  logic [swlc_pkg::CNT_W-1:0] cnt_r;
  logic [WW-1:0]   rdw_r;
  logic            issue, sweep_done;

  assign issue      = sweep_r && !cnt_r[WW];
  assign sweep_done = sweep_r && cnt_r[WW] && !rdv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      rdv_r <= issue;
      if (cmd.search_start || cmd.age_start) begin
        sweep_r <= 1'b1;
      end else if (sweep_done) begin
        sweep_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdw_r <= cnt_r[WW-1:0];
    if (cmd.search_start || cmd.age_start) begin
      cnt_r      <= '0;
      age_mode_r <= cmd.age_start;
    end else if (issue) begin
      cnt_r <= cnt_r + swlc_pkg::CNT_W'(1);
    end
  end

  // stores
  logic [swlc_pkg::SLOTS-1:0] valid_r;
  logic [swlc_pkg::OCC_W-1:0] occ_r [swlc_pkg::NAMESPACES];
  logic [SW-1:0] raddr, rslot;
  logic [DW-1:0] rd_addr;
  logic [MW-1:0] rd_mask;
  logic [AW-1:0] rd_age;
  logic          rd_vld;

  assign raddr  = {nsx_r, cnt_r[WW-1:0]};
  assign rslot  = {nsx_r, rdw_r};
  assign rd_vld = valid_r[rslot];

  logic          a_we, m_we, g_we;
  logic [SW-1:0] a_wa, m_wa, g_wa;
  logic [MW-1:0] m_wd;
  logic [AW-1:0] g_wd;

  swlc_ram #(.WIDTH(DW), .DEPTH(swlc_pkg::SLOTS)) u_addr_ram (
    .clk, .we(a_we), .waddr(a_wa), .wdata(addr_r), .raddr, .rdata(rd_addr)
  );
  swlc_ram #(.WIDTH(MW), .DEPTH(swlc_pkg::SLOTS)) u_mask_ram (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr, .rdata(rd_mask)
  );
  swlc_ram #(.WIDTH(AW), .DEPTH(swlc_pkg::SLOTS)) u_age_ram (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr, .rdata(rd_age)
  );

  // search results
  logic          hit_r, free_r, vic_r, evict_r;
  logic [WW-1:0] hitw_r, freew_r, vicw_r, tgt_r;
  logic [AW-1:0] hitage_r, vicage_r;
  logic [MW-1:0] hitmask_r, vicmask_r;
  logic [DW-1:0] vicaddr_r;
  logic          search_beat, use_free;

  assign search_beat = rdv_r && !age_mode_r;
  assign use_free    = (occ_r[nsx_r] < cap_eff) && free_r;

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
    end else if (search_beat) begin
      if (rd_vld && rd_addr == addr_r && !hit_r) begin
        hit_r     <= 1'b1;
        hitw_r    <= rdw_r;
        hitage_r  <= rd_age;
        hitmask_r <= rd_mask;
      end
      if (!rd_vld && !free_r) begin
        free_r  <= 1'b1;
        freew_r <= rdw_r;
      end
      if (rd_vld && (!vic_r || rd_age > vicage_r)) begin
        vic_r     <= 1'b1;
        vicw_r    <= rdw_r;
        vicage_r  <= rd_age;
        vicaddr_r <= rd_addr;
        vicmask_r <= rd_mask;
      end
    end
  end

  // placement of a write miss is decided as the aging sweep starts
  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      evict_r <= 1'b0;
    end else if (cmd.age_start && kind_r) begin
      evict_r <= !use_free && vic_r;
      priority if (use_free) tgt_r <= freew_r;
      else if (vic_r)        tgt_r <= vicw_r;
      else                   tgt_r <= '0;
    end
  end

  logic miss_commit;
  assign miss_commit = cmd.commit && kind_r && !hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < swlc_pkg::NAMESPACES; i++) begin
        occ_r[i] <= '0;
      end
    end else begin
      if (cmd.age_start && kind_r) begin
        if (!use_free && vic_r) begin
          valid_r[{nsx_r, vicw_r}] <= 1'b0;
        end else begin
          occ_r[nsx_r] <= occ_r[nsx_r] + swlc_pkg::OCC_W'(1);
        end
      end
      if (miss_commit) begin
        valid_r[{nsx_r, tgt_r}] <= 1'b1;
      end
    end
  end

  // ram write ports
  logic [WW-1:0] cw;
  logic          age_bump;
  assign cw       = hit_r ? hitw_r : tgt_r;
  assign age_bump = rdv_r && age_mode_r && rd_vld && (kind_r || rd_age < hitage_r);

  always_comb begin
    a_we = miss_commit;
    a_wa = {nsx_r, tgt_r};
    m_we = cmd.commit && kind_r;
    m_wa = {nsx_r, cw};
    m_wd = hit_r ? (mask_r | hitmask_r) : mask_r;
    // a write hit keeps its lru rank
    g_we = (cmd.commit && !(kind_r && hit_r)) || age_bump;
    g_wa = cmd.commit ? {nsx_r, cw} : rslot;
    g_wd = cmd.commit ? '0 : rd_age + AW'(1);
  end

  // result register
  logic          ov_r;
  logic [MW-1:0] fwd;
  assign fwd = (!kind_r && hit_r && !byp_r) ? (mask_r & ~hitmask_r) :
               (kind_r && !byp_r) ? '0 : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.respond) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_bad_namespace       <= bad_r;
      out_fully_served        <= !bad_r && !byp_r && (kind_r || (hit_r && fwd == '0));
      out_forward_mask        <= bad_r ? '0 : fwd;
      out_forward_sectors     <= bad_r ? '0 : swlc_pkg::popcount(fwd);
      out_writeback_valid     <= !bad_r && !byp_r && kind_r && evict_r;
      out_writeback_namespace <= (!bad_r && !byp_r && kind_r && evict_r) ? nsid_r : '0;
      out_writeback_address   <= (!bad_r && !byp_r && kind_r && evict_r) ? vicaddr_r : '0;
      out_writeback_mask      <= (!bad_r && !byp_r && kind_r && evict_r) ? vicmask_r : '0;
      out_writeback_sectors   <= (!bad_r && !byp_r && kind_r && evict_r) ?
                                 swlc_pkg::popcount(vicmask_r) : '0;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    sts.bypass     = bad_r || byp_r;
    sts.is_write   = kind_r;
    sts.hit        = hit_r;
    sts.sweep_done = sweep_done;
    sts.out_busy   = ov_r && !out_ready;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> occ_r[nsx_r] <= swlc_pkg::OCC_W'(swlc_pkg::ENTRIES))
    else $error("namespace occupancy above way count");
  assert property (@(posedge clk) disable iff (!rst_n)
    miss_commit |=> valid_r[$past({nsx_r, tgt_r})])
    else $error("inserted page not marked valid");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> ov_r)
    else $error("result register not loaded");

endmodule
`default_nettype wire
